FILE: rtl/sfcd_pkg.sv
package sfcd_pkg;

   // framing constants
   localparam logic [7:0] START_BYTE    = 8'h0F;
   localparam logic [4:0] LAST_POS      = 5'd24;
   localparam logic [4:0] LAST_DATA_POS = 5'd22;
   localparam logic [4:0] CH_BITS       = 5'd11;
   localparam logic [4:0] BYTE_BITS     = 5'd8;

   // widths
   localparam int VALUE_W   = 11;
   localparam int CHANNEL_W = 4;
   localparam int ACC_W     = 18;

   // result kinds
   localparam logic KIND_CHANNEL = 1'b0;
   localparam logic KIND_DONE    = 1'b1;

   localparam int DEFAULT_CHANNELS = 6;

   typedef struct packed {
      logic                 kind;
      logic [CHANNEL_W-1:0] channel;
      logic [VALUE_W-1:0]   value;
   } result_type;

endpackage

FILE: rtl/sbus_frame_channel_decoder_unit.sv
// sbus frame channel decoder
// Takes received bytes on the req_ channel, one word per handshake. While idle
// it drops every byte until the start byte 0x0F; it then counts a 25-byte frame.
// Data bytes (positions 1 to 22) are packed lsb first into an 18-bit accumulator
// and every 11 bits give one rsp_ word with kind channel, the channel index and
// the value, up to CHANNELS channels per frame. The flag byte gives nothing.
// The 25th byte gives a frame-complete word (kind 1, channel and value 0) and
// the decoder returns to idle.
// A result passes through the input register and then the result register
// before it appears on rsp_valid. Throughput: one byte per cycle while rsp_stall
// is low, set by the combinational accumulate-and-extract step between the two
// registers. A byte that gives no result simply leaves the pipeline.
// When the receiver stalls, the result register holds its word and the input
// register holds its byte; req_stall rises only while both are full and
// rsp_stall is high. A synchronous reset empties both registers and returns
// the decoder to idle, awaiting a start byte.
module sbus_frame_channel_decoder_unit
   import sfcd_pkg::*;
#(
   parameter int CHANNELS = DEFAULT_CHANNELS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_kind,
   output logic [CHANNEL_W-1:0] rsp_channel,
   output logic [VALUE_W-1:0]   rsp_value
);

   localparam logic [4:0] NUM_CH = 5'(CHANNELS);

   // pipeline registers
   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff, in_byte_in;
   logic             out_valid_ff, out_valid_in;
   result_type       out_word_ff, out_word_in;

   // decoder state
   logic [4:0]       byte_count_ff, byte_count_in;
   logic [ACC_W-1:0] pending_bits_ff, pending_bits_in;
   logic [4:0]       pending_count_ff, pending_count_in;
   logic [4:0]       next_channel_ff, next_channel_in;

   logic             out_free;
   logic             step;
   logic             emit;
   result_type       word;
   logic [ACC_W-1:0] acc;
   logic [4:0]       acc_count;

   // handshake
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_byte_in  = req_rx_byte;
      end
   end

   // accumulate the current byte at the fill position
   assign acc       = pending_bits_ff
                    | (ACC_W'(in_byte_ff) << pending_count_ff[3:0]);
   assign acc_count = pending_count_ff + BYTE_BITS;

   // frame decode
   always_comb begin
      byte_count_in    = byte_count_ff;
      pending_bits_in  = pending_bits_ff;
      pending_count_in = pending_count_ff;
      next_channel_in  = next_channel_ff;
      emit             = 1'b0;
      word.kind        = KIND_CHANNEL;
      word.channel     = '0;
      word.value       = '0;
      if (step) begin
         if (byte_count_ff == 5'd0) begin
            if (in_byte_ff == START_BYTE) begin
               byte_count_in    = 5'd1;
               pending_bits_in  = '0;
               pending_count_in = '0;
               next_channel_in  = '0;
            end
         end else if (byte_count_ff >= LAST_POS) begin
            byte_count_in = 5'd0;
            emit          = 1'b1;
            word.kind     = KIND_DONE;
         end else begin
            byte_count_in = byte_count_ff + 5'd1;
            if (byte_count_ff <= LAST_DATA_POS && next_channel_ff < NUM_CH) begin
               pending_bits_in  = acc;
               pending_count_in = acc_count;
               if (acc_count >= CH_BITS) begin
                  emit             = 1'b1;
                  word.channel     = next_channel_ff[CHANNEL_W-1:0];
                  word.value       = acc[VALUE_W-1:0];
                  pending_bits_in  = acc >> CH_BITS;
                  pending_count_in = acc_count - CH_BITS;
                  next_channel_in  = next_channel_ff + 5'd1;
               end
            end
         end
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      if (out_free) begin
         out_valid_in = step && emit;
         out_word_in  = word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         byte_count_ff    <= '0;
         pending_bits_ff  <= '0;
         pending_count_ff <= '0;
         next_channel_ff  <= '0;
      end else begin
         in_valid_ff      <= in_valid_in;
         out_valid_ff     <= out_valid_in;
         byte_count_ff    <= byte_count_in;
         pending_bits_ff  <= pending_bits_in;
         pending_count_ff <= pending_count_in;
         next_channel_ff  <= next_channel_in;
      end
      in_byte_ff  <= in_byte_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_kind    = out_word_ff.kind;
   assign rsp_channel = out_word_ff.channel;
   assign rsp_value   = out_word_ff.value;

   // checks
   a_done_is_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_DONE |-> rsp_channel == '0 && rsp_value == '0)
      else $error("frame-complete word carries channel data");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while result register can move");

   a_channel_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_CHANNEL |-> 5'(rsp_channel) < NUM_CH)
      else $error("channel index beyond configured channel count");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_count_ff < CH_BITS)
      else $error("accumulator holds a whole unsent channel");

endmodule
